/* rtl/mfq_pkg.sv */
`timescale 1ns / 1ps

package mfq_pkg;

  // Fixed field widths
  localparam int IN_W    = 16;
  localparam int SHIFT_W = 5;
  localparam int LLR_W   = 4;
  localparam int PROD_W  = 2 * IN_W;
  localparam int SUM_W   = PROD_W + 1;

  // Default saturation width of compensated samples
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Soft value limits
  localparam int LLR_MAX = 7;
  localparam int LLR_MIN = -8;

  // Per-stage load enables of the pipeline
  typedef struct packed {
    logic ld_mul;
    logic ld_sat;
    logic ld_out;
  } pipe_ctl_t;

endpackage

/* rtl/mfq_if.sv */
`timescale 1ns / 1ps

// Input word: received samples and channel estimates of both antennas
interface mfq_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mfq_pkg::IN_W-1:0]        rx0_re;
  logic signed [mfq_pkg::IN_W-1:0]        rx0_im;
  logic signed [mfq_pkg::IN_W-1:0]        rx1_re;
  logic signed [mfq_pkg::IN_W-1:0]        rx1_im;
  logic signed [mfq_pkg::IN_W-1:0]        ch0_re;
  logic signed [mfq_pkg::IN_W-1:0]        ch0_im;
  logic signed [mfq_pkg::IN_W-1:0]        ch1_re;
  logic signed [mfq_pkg::IN_W-1:0]        ch1_im;
  logic        [mfq_pkg::SHIFT_W-1:0]     product_shift;

  modport source (
    output valid, rx0_re, rx0_im, rx1_re, rx1_im,
    output ch0_re, ch0_im, ch1_re, ch1_im, product_shift,
    input  ready
  );
  modport sink (
    input  valid, rx0_re, rx0_im, rx1_re, rx1_im,
    input  ch0_re, ch0_im, ch1_re, ch1_im, product_shift,
    output ready
  );
endinterface

// Output word: compensated sample and soft values
interface mfq_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mfq_pkg::IN_W-1:0]    comp_re;
  logic signed [mfq_pkg::IN_W-1:0]    comp_im;
  logic signed [mfq_pkg::LLR_W-1:0]   llr_re;
  logic signed [mfq_pkg::LLR_W-1:0]   llr_im;

  modport source (
    output valid, comp_re, comp_im, llr_re, llr_im,
    input  ready
  );
  modport sink (
    input  valid, comp_re, comp_im, llr_re, llr_im,
    output ready
  );
endinterface

/* rtl/matched_filter_mrc_llr_quantizer.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake       Word
// din       in   valid/ready     rx0/rx1/ch0/ch1 re,im; product_shift
// dout      out  valid/ready     comp_re, comp_im, llr_re, llr_im
// cfg       in   cfg_we          cfg_wdata -> two_rx_antennas
//
// One word per clock sustained while dout is ready; three register
// stages: multiply, shift and saturate, combine and quantize.
// Each stage holds its word under backpressure and fills bubbles, so din
// stays ready while dout stalls until all three stages are full.
// rst clears the valid bits and the antenna mode register.
module matched_filter_mrc_llr_quantizer #(
  parameter int SAMPLE_WIDTH = mfq_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  mfq_in_if.sink        din,
  mfq_out_if.source     dout
);

  logic               two_rx_antennas;
  logic               v_mul, v_sat, v_out;
  logic               rdy_mul, rdy_sat, rdy_out;
  mfq_pkg::pipe_ctl_t ctl;

  logic signed [SAMPLE_WIDTH-1:0] a0_re, a0_im, a1_re, a1_im;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      two_rx_antennas <= 1'b0;
    end else if (cfg_we) begin
      two_rx_antennas <= cfg_wdata;
    end
  end

  // Stage readiness and load enables
  always_comb begin
    rdy_out    = !v_out || dout.ready;
    rdy_sat    = !v_sat || rdy_out;
    rdy_mul    = !v_mul || rdy_sat;
    ctl.ld_mul = din.valid && rdy_mul;
    ctl.ld_sat = v_mul && rdy_sat;
    ctl.ld_out = v_sat && rdy_out;
  end

  assign din.ready  = rdy_mul;
  assign dout.valid = v_out;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v_mul <= 1'b0;
      v_sat <= 1'b0;
      v_out <= 1'b0;
    end else begin
      if (rdy_mul) begin
        v_mul <= din.valid;
      end
      if (rdy_sat) begin
        v_sat <= v_mul;
      end
      if (rdy_out) begin
        v_out <= v_sat;
      end
    end
  end

  // Antenna 0 lane
  mfq_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane0 (
    .clk    (clk),
    .ctl    (ctl),
    .rx_re  (din.rx0_re),
    .rx_im  (din.rx0_im),
    .ch_re  (din.ch0_re),
    .ch_im  (din.ch0_im),
    .shift  (din.product_shift),
    .res_re (a0_re),
    .res_im (a0_im)
  );

  // Antenna 1 lane
  mfq_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane1 (
    .clk    (clk),
    .ctl    (ctl),
    .rx_re  (din.rx1_re),
    .rx_im  (din.rx1_im),
    .ch_re  (din.ch1_re),
    .ch_im  (din.ch1_im),
    .shift  (din.product_shift),
    .res_re (a1_re),
    .res_im (a1_im)
  );

  // Combine and quantize
  mfq_merge #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_merge (
    .clk     (clk),
    .ctl     (ctl),
    .two_rx  (two_rx_antennas),
    .a0_re   (a0_re),
    .a0_im   (a0_im),
    .a1_re   (a1_re),
    .a1_im   (a1_im),
    .comp_re (dout.comp_re),
    .comp_im (dout.comp_im),
    .llr_re  (dout.llr_re),
    .llr_im  (dout.llr_im)
  );

endmodule

/* rtl/mfq_lane.sv */
`timescale 1ns / 1ps

// One antenna: y * conj(h), shift, saturate. Two register stages.
module mfq_lane #(
  parameter int SAMPLE_WIDTH = mfq_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  mfq_pkg::pipe_ctl_t                  ctl,
  input  logic signed [mfq_pkg::IN_W-1:0]     rx_re,
  input  logic signed [mfq_pkg::IN_W-1:0]     rx_im,
  input  logic signed [mfq_pkg::IN_W-1:0]     ch_re,
  input  logic signed [mfq_pkg::IN_W-1:0]     ch_im,
  input  logic        [mfq_pkg::SHIFT_W-1:0]  shift,
  output logic signed [SAMPLE_WIDTH-1:0]      res_re,
  output logic signed [SAMPLE_WIDTH-1:0]      res_im
);

  localparam logic signed [mfq_pkg::SUM_W-1:0] SAT_HI =
    mfq_pkg::SUM_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [mfq_pkg::SUM_W-1:0] SAT_LO = -SAT_HI - 2'sd1;

  logic signed [mfq_pkg::PROD_W-1:0] p_rr, p_ii, p_ri, p_ir;
  logic        [mfq_pkg::SHIFT_W-1:0] shift_q;
  logic signed [mfq_pkg::SUM_W-1:0]  sum_re, sum_im, sh_re, sh_im;
  logic signed [SAMPLE_WIDTH-1:0]    sat_re, sat_im;

  // Stage 1: four partial products
  always_ff @(posedge clk) begin
    if (ctl.ld_mul) begin
      p_rr    <= ch_re * rx_re;
      p_ii    <= ch_im * rx_im;
      p_ri    <= ch_re * rx_im;
      p_ir    <= ch_im * rx_re;
      shift_q <= shift;
    end
  end

  // Exact 33-bit sums, arithmetic shift
  always_comb begin
    sum_re = mfq_pkg::SUM_W'(p_rr) + mfq_pkg::SUM_W'(p_ii);
    sum_im = mfq_pkg::SUM_W'(p_ri) - mfq_pkg::SUM_W'(p_ir);
    sh_re  = sum_re >>> shift_q;
    sh_im  = sum_im >>> shift_q;
  end

  // Saturate to sample width
  always_comb begin
    priority if (sh_re > SAT_HI) begin
      sat_re = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (sh_re < SAT_LO) begin
      sat_re = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      sat_re = sh_re[SAMPLE_WIDTH-1:0];
    end
    priority if (sh_im > SAT_HI) begin
      sat_im = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (sh_im < SAT_LO) begin
      sat_im = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      sat_im = sh_im[SAMPLE_WIDTH-1:0];
    end
  end

  // Stage 2 register
  always_ff @(posedge clk) begin
    if (ctl.ld_sat) begin
      res_re <= sat_re;
      res_im <= sat_im;
    end
  end

endmodule

/* rtl/mfq_merge.sv */
`timescale 1ns / 1ps

// MRC or lane 0 alone, quantize to soft values; output register.
module mfq_merge #(
  parameter int SAMPLE_WIDTH = mfq_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                               clk,
  input  mfq_pkg::pipe_ctl_t                 ctl,
  input  logic                               two_rx,
  input  logic signed [SAMPLE_WIDTH-1:0]     a0_re,
  input  logic signed [SAMPLE_WIDTH-1:0]     a0_im,
  input  logic signed [SAMPLE_WIDTH-1:0]     a1_re,
  input  logic signed [SAMPLE_WIDTH-1:0]     a1_im,
  output logic signed [mfq_pkg::IN_W-1:0]    comp_re,
  output logic signed [mfq_pkg::IN_W-1:0]    comp_im,
  output logic signed [mfq_pkg::LLR_W-1:0]   llr_re,
  output logic signed [mfq_pkg::LLR_W-1:0]   llr_im
);

  localparam int CW = SAMPLE_WIDTH + 1;
  localparam logic signed [CW-1:0] SAT_HI =
    CW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [CW-1:0] SAT_LO = -SAT_HI - 2'sd1;
  localparam logic signed [SAMPLE_WIDTH-1:0] L_HI = SAMPLE_WIDTH'(mfq_pkg::LLR_MAX);
  localparam logic signed [SAMPLE_WIDTH-1:0] L_LO = SAMPLE_WIDTH'(mfq_pkg::LLR_MIN);

  logic signed [CW-1:0]           add_re, add_im;
  logic signed [SAMPLE_WIDTH-1:0] mrc_re, mrc_im, sel_re, sel_im;
  logic signed [SAMPLE_WIDTH-1:0] q_re, q_im;

  // Halve each antenna, add and saturate; lane 0 alone if not two_rx
  always_comb begin
    add_re = CW'(a0_re >>> 1) + CW'(a1_re >>> 1);
    add_im = CW'(a0_im >>> 1) + CW'(a1_im >>> 1);
    priority if (add_re > SAT_HI) begin
      mrc_re = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (add_re < SAT_LO) begin
      mrc_re = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      mrc_re = add_re[SAMPLE_WIDTH-1:0];
    end
    priority if (add_im > SAT_HI) begin
      mrc_im = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (add_im < SAT_LO) begin
      mrc_im = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      mrc_im = add_im[SAMPLE_WIDTH-1:0];
    end
    sel_re = two_rx ? mrc_re : a0_re;
    sel_im = two_rx ? mrc_im : a0_im;
  end

  // Clamp to soft value range
  always_comb begin
    priority if (sel_re > L_HI) begin
      q_re = L_HI;
    end else if (sel_re < L_LO) begin
      q_re = L_LO;
    end else begin
      q_re = sel_re;
    end
    priority if (sel_im > L_HI) begin
      q_im = L_HI;
    end else if (sel_im < L_LO) begin
      q_im = L_LO;
    end else begin
      q_im = sel_im;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      comp_re <= mfq_pkg::IN_W'(sel_re);
      comp_im <= mfq_pkg::IN_W'(sel_im);
      llr_re  <= q_re[mfq_pkg::LLR_W-1:0];
      llr_im  <= q_im[mfq_pkg::LLR_W-1:0];
    end
  end

endmodule
